// ----- hw/rtl/bab_pkg.sv -----
// shared types and constants for the bus to apb bridge
// no dependencies
package bab_pkg;

  localparam int unsigned DATA_BITS = 64;
  localparam int unsigned APB_BITS  = 32;
  localparam int unsigned STRB_BITS = 8;
  localparam int unsigned APB_STRB  = 4;
  localparam int unsigned PROT_BITS = 3;

  localparam logic [APB_BITS-1:0]  WORD_STEP   = APB_BITS'(4);
  localparam logic [STRB_BITS-1:0] ALL_STROBES = '1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETUP  = 2'd1,
    PH_ACCESS = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                 req_accept;
    logic                 resp_valid;
    logic [DATA_BITS-1:0] resp_rdata;
    logic                 resp_error;
    logic [APB_BITS-1:0]  apb_addr;
    logic                 apb_write;
    logic [APB_BITS-1:0]  apb_wdata;
    logic [APB_STRB-1:0]  apb_strb;
    logic                 apb_sel;
    logic                 apb_enable;
    logic [PROT_BITS-1:0] apb_prot;
  } result_t;

endpackage

// ----- hw/rtl/bus_to_apb_bridge.sv -----
// top level of the bus to apb bridge: beat handshake around the controller
// depends on bab_pkg and bab_ctrl
// the result of an accepted input beat is registered and presented in the cycle after it
// throughput: one beat per cycle while out_ready holds, the result register is reloaded as it is taken
// reset: synchronous active-high rst returns the controller to idle with cleared registers
// and empties the result register
module bus_to_apb_bridge import bab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_valid,
  input  logic [APB_BITS-1:0]  req_addr,
  input  logic                 req_write,
  input  logic [DATA_BITS-1:0] req_wdata,
  input  logic [STRB_BITS-1:0] req_wstrb,
  input  logic                 req_last,
  input  logic                 apb_ready,
  input  logic                 apb_error,
  input  logic [APB_BITS-1:0]  apb_rdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 req_accept,
  output logic                 resp_valid,
  output logic [DATA_BITS-1:0] resp_rdata,
  output logic                 resp_error,
  output logic [APB_BITS-1:0]  apb_addr,
  output logic                 apb_write,
  output logic [APB_BITS-1:0]  apb_wdata,
  output logic [APB_STRB-1:0]  apb_strb,
  output logic                 apb_sel,
  output logic                 apb_enable,
  output logic [PROT_BITS-1:0] apb_prot
);

  logic    step;
  result_t res;
  result_t res_q;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  bab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .req_valid (req_valid),
    .req_addr  (req_addr),
    .req_write (req_write),
    .req_wdata (req_wdata),
    .req_wstrb (req_wstrb),
    .req_last  (req_last),
    .apb_ready (apb_ready),
    .apb_error (apb_error),
    .apb_rdata (apb_rdata),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_q <= res;
  end

  assign req_accept = res_q.req_accept;
  assign resp_valid = res_q.resp_valid;
  assign resp_rdata = res_q.resp_rdata;
  assign resp_error = res_q.resp_error;
  assign apb_addr   = res_q.apb_addr;
  assign apb_write  = res_q.apb_write;
  assign apb_wdata  = res_q.apb_wdata;
  assign apb_strb   = res_q.apb_strb;
  assign apb_sel    = res_q.apb_sel;
  assign apb_enable = res_q.apb_enable;
  assign apb_prot   = res_q.apb_prot;

endmodule

// ----- hw/rtl/bab_ctrl.sv -----
// bridge controller: phase state machine and transfer registers, one step per beat
// depends on bab_pkg
module bab_ctrl import bab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 req_valid,
  input  logic [APB_BITS-1:0]  req_addr,
  input  logic                 req_write,
  input  logic [DATA_BITS-1:0] req_wdata,
  input  logic [STRB_BITS-1:0] req_wstrb,
  input  logic                 req_last,
  input  logic                 apb_ready,
  input  logic                 apb_error,
  input  logic [APB_BITS-1:0]  apb_rdata,
  output result_t              res
);

  phase_t               phase, phase_next;
  logic                 resp_pulse, resp_pulse_next;
  logic [APB_BITS-1:0]  word_addr, word_addr_next;
  logic [DATA_BITS-1:0] write_data, write_data_next;
  logic [DATA_BITS-1:0] read_data, read_data_next;
  logic                 is_write, is_write_next;
  logic [STRB_BITS-1:0] strobes, strobes_next;
  logic                 select_flag, select_flag_next;
  logic                 enable_flag, enable_flag_next;
  logic                 error_flag, error_flag_next;
  logic                 pending, pending_next;
  logic                 upper;

  assign upper = word_addr[2];

  // result from the registers as they stand
  always_comb begin
    res            = '0;
    res.req_accept = (phase == PH_IDLE);
    res.resp_valid = resp_pulse;
    res.resp_rdata = read_data;
    res.resp_error = error_flag;
    res.apb_addr   = word_addr;
    res.apb_write  = is_write;
    res.apb_wdata  = upper ? write_data[DATA_BITS-1:APB_BITS] : write_data[APB_BITS-1:0];
    res.apb_strb   = upper ? strobes[STRB_BITS-1:APB_STRB] : strobes[APB_STRB-1:0];
    res.apb_sel    = select_flag;
    res.apb_enable = enable_flag;
    res.apb_prot   = '0;
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (req_valid) phase_next = req_last ? PH_SETUP : PH_ERROR;
      end
      PH_SETUP:  phase_next = PH_ACCESS;
      PH_ACCESS: begin
        if (apb_ready) phase_next = pending ? PH_SETUP : PH_IDLE;
      end
      PH_ERROR:  phase_next = PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  // transfer registers
  always_comb begin
    resp_pulse_next  = 1'b0;
    word_addr_next   = word_addr;
    write_data_next  = write_data;
    read_data_next   = read_data;
    is_write_next    = is_write;
    strobes_next     = strobes;
    select_flag_next = select_flag;
    enable_flag_next = enable_flag;
    error_flag_next  = error_flag;
    pending_next     = pending;
    unique case (phase)
      PH_IDLE: begin
        error_flag_next  = 1'b0;
        enable_flag_next = 1'b0;
        select_flag_next = 1'b0;
        pending_next     = 1'b0;
        if (req_valid) begin
          is_write_next    = req_write;
          word_addr_next   = {req_addr[APB_BITS-1:2], 2'b00};
          write_data_next  = req_wdata;
          strobes_next     = req_wstrb;
          pending_next     = (req_wstrb == ALL_STROBES);
          select_flag_next = req_last;
        end
      end
      PH_SETUP: enable_flag_next = 1'b1;
      PH_ACCESS: begin
        error_flag_next = apb_error;
        if (apb_ready) begin
          enable_flag_next = 1'b0;
          select_flag_next = 1'b0;
          if (upper) read_data_next[DATA_BITS-1:APB_BITS] = apb_rdata;
          else       read_data_next[APB_BITS-1:0] = apb_rdata;
          if (pending) begin
            pending_next     = 1'b0;
            word_addr_next   = word_addr + WORD_STEP;
            select_flag_next = 1'b1;
          end else begin
            resp_pulse_next = 1'b1;
          end
        end
      end
      PH_ERROR: begin
        resp_pulse_next = 1'b1;
        read_data_next  = '1;
        error_flag_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      resp_pulse  <= 1'b0;
      word_addr   <= '0;
      write_data  <= '0;
      read_data   <= '0;
      is_write    <= 1'b0;
      strobes     <= '0;
      select_flag <= 1'b0;
      enable_flag <= 1'b0;
      error_flag  <= 1'b0;
      pending     <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      resp_pulse  <= resp_pulse_next;
      word_addr   <= word_addr_next;
      write_data  <= write_data_next;
      read_data   <= read_data_next;
      is_write    <= is_write_next;
      strobes     <= strobes_next;
      select_flag <= select_flag_next;
      enable_flag <= enable_flag_next;
      error_flag  <= error_flag_next;
      pending     <= pending_next;
    end
  end

endmodule

// ----- verif/bab_checker.sv -----
// cycle-accurate predictor and comparator for the bus to apb bridge
// watches the input and result beat channels and counts mismatches for the testbench top
// depends on bab_pkg
module bab_checker import bab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 req_valid,
  input  logic [APB_BITS-1:0]  req_addr,
  input  logic                 req_write,
  input  logic [DATA_BITS-1:0] req_wdata,
  input  logic [STRB_BITS-1:0] req_wstrb,
  input  logic                 req_last,
  input  logic                 apb_ready,
  input  logic                 apb_error,
  input  logic [APB_BITS-1:0]  apb_rdata,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 req_accept,
  input  logic                 resp_valid,
  input  logic [DATA_BITS-1:0] resp_rdata,
  input  logic                 resp_error,
  input  logic [APB_BITS-1:0]  apb_addr,
  input  logic                 apb_write,
  input  logic [APB_BITS-1:0]  apb_wdata,
  input  logic [APB_STRB-1:0]  apb_strb,
  input  logic                 apb_sel,
  input  logic                 apb_enable,
  input  logic [PROT_BITS-1:0] apb_prot,
  output int                   mismatches,
  output int                   pending,
  output int                   beats_checked,
  output int                   responses,
  output int                   error_responses
);

  // predicted controller state
  phase_t               ctl_phase;
  logic                 pulse_q;
  logic [APB_BITS-1:0]  word_q;
  logic [DATA_BITS-1:0] wdata_q;
  logic [DATA_BITS-1:0] rdata_q;
  logic                 write_q;
  logic [STRB_BITS-1:0] strb_q;
  logic                 sel_q;
  logic                 enable_q;
  logic                 error_q;
  logic                 second_q;

  result_t predicted_outputs[$];

  function automatic result_t bridge_cycle(
    input logic                 rv,
    input logic [APB_BITS-1:0]  ra,
    input logic                 rw,
    input logic [DATA_BITS-1:0] rwd,
    input logic [STRB_BITS-1:0] rs,
    input logic                 rl,
    input logic                 ar,
    input logic                 ae,
    input logic [APB_BITS-1:0]  ard
  );
    result_t r;
    logic    hi_half;
    hi_half = word_q[2];
    r.req_accept = (ctl_phase == PH_IDLE);
    r.resp_valid = pulse_q;
    r.resp_rdata = rdata_q;
    r.resp_error = error_q;
    r.apb_addr   = word_q;
    r.apb_write  = write_q;
    r.apb_wdata  = hi_half ? wdata_q[63:32] : wdata_q[31:0];
    r.apb_strb   = hi_half ? strb_q[7:4] : strb_q[3:0];
    r.apb_sel    = sel_q;
    r.apb_enable = enable_q;
    r.apb_prot   = '0;

    pulse_q = 1'b0;
    case (ctl_phase)
      PH_IDLE: begin
        error_q  = 1'b0;
        enable_q = 1'b0;
        sel_q    = 1'b0;
        second_q = 1'b0;
        if (rv) begin
          write_q  = rw;
          word_q   = {ra[APB_BITS-1:2], 2'b00};
          wdata_q  = rwd;
          strb_q   = rs;
          second_q = (rs == ALL_STROBES);
          if (rl) begin
            sel_q     = 1'b1;
            ctl_phase = PH_SETUP;
          end else begin
            ctl_phase = PH_ERROR;
          end
        end
      end
      PH_SETUP: begin
        enable_q  = 1'b1;
        ctl_phase = PH_ACCESS;
      end
      PH_ACCESS: begin
        error_q = ae;
        if (ar) begin
          enable_q = 1'b0;
          sel_q    = 1'b0;
          if (hi_half) rdata_q[63:32] = ard;
          else rdata_q[31:0] = ard;
          if (second_q) begin
            // second word of a full-strobe write or read
            second_q  = 1'b0;
            word_q    = word_q + WORD_STEP;
            sel_q     = 1'b1;
            ctl_phase = PH_SETUP;
          end else begin
            pulse_q   = 1'b1;
            ctl_phase = PH_IDLE;
          end
        end
      end
      default: begin
        pulse_q   = 1'b1;
        rdata_q   = '1;
        error_q   = 1'b1;
        ctl_phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      ctl_phase = PH_IDLE;
      pulse_q   = 1'b0;
      word_q    = '0;
      wdata_q   = '0;
      rdata_q   = '0;
      write_q   = 1'b0;
      strb_q    = '0;
      sel_q     = 1'b0;
      enable_q  = 1'b0;
      error_q   = 1'b0;
      second_q  = 1'b0;
      predicted_outputs.delete();
    end else begin
      // compare before predicting, so a stray result beat never meets its own prediction
      if (out_valid && out_ready) begin
        if (predicted_outputs.size() == 0) begin
          $error("result beat with no prediction waiting");
          mismatches++;
        end else begin
          want = predicted_outputs.pop_front();
          check_field("req_accept", want.req_accept, req_accept);
          check_field("resp_valid", want.resp_valid, resp_valid);
          check_field("resp_rdata", want.resp_rdata, resp_rdata);
          check_field("resp_error", want.resp_error, resp_error);
          check_field("apb_addr", want.apb_addr, apb_addr);
          check_field("apb_write", want.apb_write, apb_write);
          check_field("apb_wdata", want.apb_wdata, apb_wdata);
          check_field("apb_strb", want.apb_strb, apb_strb);
          check_field("apb_sel", want.apb_sel, apb_sel);
          check_field("apb_enable", want.apb_enable, apb_enable);
          check_field("apb_prot", want.apb_prot, apb_prot);
          beats_checked++;
          if (want.resp_valid) begin
            responses++;
            if (want.resp_error) error_responses++;
          end
        end
      end
      if (in_valid && in_ready)
        predicted_outputs.push_back(bridge_cycle(req_valid, req_addr, req_write, req_wdata,
                                                 req_wstrb, req_last, apb_ready, apb_error,
                                                 apb_rdata));
    end
    pending = predicted_outputs.size();
  end

endmodule

// ----- verif/tb_bus_to_apb_bridge.sv -----
// testbench top for the bus to apb bridge: clock, reset, beat stimulus and verdict
// depends on bab_pkg, bus_to_apb_bridge and bab_checker
module tb_bus_to_apb_bridge;
  import bab_pkg::*;

  localparam int RANDOM_ITEMS = 550;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_valid = 1'b0;
  logic [APB_BITS-1:0]  req_addr = '0;
  logic                 req_write = 1'b0;
  logic [DATA_BITS-1:0] req_wdata = '0;
  logic [STRB_BITS-1:0] req_wstrb = '0;
  logic                 req_last = 1'b0;
  logic                 apb_ready = 1'b0;
  logic                 apb_error = 1'b0;
  logic [APB_BITS-1:0]  apb_rdata = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 req_accept;
  logic                 resp_valid;
  logic [DATA_BITS-1:0] resp_rdata;
  logic                 resp_error;
  logic [APB_BITS-1:0]  apb_addr;
  logic                 apb_write;
  logic [APB_BITS-1:0]  apb_wdata;
  logic [APB_STRB-1:0]  apb_strb;
  logic                 apb_sel;
  logic                 apb_enable;
  logic [PROT_BITS-1:0] apb_prot;

  int mismatches;
  int pending;
  int beats_checked;
  int responses;
  int error_responses;

  bit calm = 1'b0;
  int sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bus_to_apb_bridge u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_valid  (req_valid),
    .req_addr   (req_addr),
    .req_write  (req_write),
    .req_wdata  (req_wdata),
    .req_wstrb  (req_wstrb),
    .req_last   (req_last),
    .apb_ready  (apb_ready),
    .apb_error  (apb_error),
    .apb_rdata  (apb_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .req_accept (req_accept),
    .resp_valid (resp_valid),
    .resp_rdata (resp_rdata),
    .resp_error (resp_error),
    .apb_addr   (apb_addr),
    .apb_write  (apb_write),
    .apb_wdata  (apb_wdata),
    .apb_strb   (apb_strb),
    .apb_sel    (apb_sel),
    .apb_enable (apb_enable),
    .apb_prot   (apb_prot)
  );

  bab_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_valid       (req_valid),
    .req_addr        (req_addr),
    .req_write       (req_write),
    .req_wdata       (req_wdata),
    .req_wstrb       (req_wstrb),
    .req_last        (req_last),
    .apb_ready       (apb_ready),
    .apb_error       (apb_error),
    .apb_rdata       (apb_rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .req_accept      (req_accept),
    .resp_valid      (resp_valid),
    .resp_rdata      (resp_rdata),
    .resp_error      (resp_error),
    .apb_addr        (apb_addr),
    .apb_write       (apb_write),
    .apb_wdata       (apb_wdata),
    .apb_strb        (apb_strb),
    .apb_sel         (apb_sel),
    .apb_enable      (apb_enable),
    .apb_prot        (apb_prot),
    .mismatches      (mismatches),
    .pending         (pending),
    .beats_checked   (beats_checked),
    .responses       (responses),
    .error_responses (error_responses)
  );

  function automatic logic [DATA_BITS-1:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  // bias some addresses to the top of the space so the second word can wrap
  function automatic logic [APB_BITS-1:0] rand_addr();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
      1: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(
    input logic                 rv,
    input logic [APB_BITS-1:0]  ra,
    input logic                 rw,
    input logic [DATA_BITS-1:0] rwd,
    input logic [STRB_BITS-1:0] rs,
    input logic                 rl,
    input logic                 ar,
    input logic                 ae,
    input logic [APB_BITS-1:0]  ard
  );
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    req_valid = rv;
    req_addr  = ra;
    req_write = rw;
    req_wdata = rwd;
    req_wstrb = rs;
    req_last  = rl;
    apb_ready = ar;
    apb_error = ae;
    apb_rdata = ard;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // one bus cycle, slave answering at random, now and then a new request
  task automatic slave_cycle();
    send_beat($urandom_range(0, 3) == 0, rand_addr(), 1'($urandom_range(0, 1)), rand_wide(),
              8'($urandom), 1'b1, $urandom_range(0, 2) != 0, $urandom_range(0, 4) == 0,
              $urandom);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        hold = $urandom_range(1, 5) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    int  pick;
    int  follow;
    bit  paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // idle, then a plain lower-half read with all-ones slave data
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    send_beat(1'b1, 32'h0000_0000, 1'b0, '0, 8'h0F, 1'b1, 1'b0, 1'b0, '0);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b1, 1'b0, '1);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    // full-strobe write at the top of the space: wait state with error, then wrap to zero
    send_beat(1'b1, '1, 1'b1, '1, ALL_STROBES, 1'b1, 1'b0, 1'b0, '0);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b1, '0);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b1, 1'b0, 32'hA5A5_5A5A);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b1, 1'b1, 32'h1234_5678);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    // burst request is refused through the error phase
    send_beat(1'b1, 32'h0000_0010, 1'b1, '0, 8'h00, 1'b0, 1'b1, 1'b0, '0);
    send_beat(1'b1, 32'h0000_0020, 1'b0, '1, '1, 1'b1, 1'b1, 1'b1, '1);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    // upper-half read, requests while busy are ignored
    send_beat(1'b1, 32'h0000_0004, 1'b0, 64'h0123_4567_89AB_CDEF, 8'hF0, 1'b1, 1'b1, 1'b0, '0);
    send_beat(1'b1, 32'h0000_0008, 1'b1, '1, '1, 1'b1, 1'b1, 1'b0, '0);
    send_beat(1'b1, 32'h0000_000C, 1'b1, '1, '1, 1'b0, 1'b1, 1'b0, 32'hDEAD_BEEF);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    send_beat(1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent > RANDOM_ITEMS - 60);
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        send_beat(1'b1, rand_addr(), 1'($urandom_range(0, 1)), rand_wide(),
                  ($urandom_range(0, 2) == 0) ? ALL_STROBES : 8'($urandom), 1'b1,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        follow = $urandom_range(3, 10);
        repeat (follow) slave_cycle();
      end else if (pick < 18) begin
        send_beat(1'b1, rand_addr(), 1'($urandom_range(0, 1)), rand_wide(), 8'($urandom),
                  1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        repeat (2) slave_cycle();
      end else begin
        repeat (4)
          send_beat(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)), rand_wide(),
                    8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), $urandom);
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d result beats, %0d bridge responses, %0d of them with error",
             beats_checked, responses, error_responses);
    if (mismatches == 0) begin
      $display("[bus_to_apb_bridge] OK");
    end else begin
      $display("[bus_to_apb_bridge] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("[bus_to_apb_bridge] ERROR");
    $finish;
  end

endmodule

// ----- bus_to_apb_bridge.f -----
hw/rtl/bab_pkg.sv
hw/rtl/bab_ctrl.sv
hw/rtl/bus_to_apb_bridge.sv
verif/bab_checker.sv
verif/tb_bus_to_apb_bridge.sv
